/* hdl/sorted_priority_queue_core_assert.svh */
// assertion macros used by the queue checker
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// clocked check, quiet while reset is high
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define SPQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/spq_pkg.sv */
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic                     enq_en;
    logic                     deq_en;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// one slot of the sorted register chain
module spq_cell (
  input  logic                             clk,
  input  spq_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic                             left_shift,
  input  logic signed [spq_pkg::DATA_W-1:0] left_value,
  input  logic signed [spq_pkg::DATA_W-1:0] right_value,
  output logic                             shift,
  output logic signed [spq_pkg::DATA_W-1:0] slot_value
);

  logic signed [spq_pkg::DATA_W-1:0] slot;

  // slot sits at or behind the insert point: empty, or strictly greater
  assign shift      = !occupied || (slot > ctrl.value);
  assign slot_value = slot;

  // insert moves entries up one slot, dequeue moves them down one slot
  always_ff @(posedge clk) begin
    if (ctrl.enq_en && shift) begin
      slot <= left_shift ? left_value : ctrl.value;
    end else if (ctrl.deq_en) begin
      slot <= right_value;
    end
  end

endmodule

/* hdl/sorted_priority_queue_core.sv */
// sorted minimum priority queue: top level with the cell chain and result register
//
// Input channel (in_valid/in_ready): action 0 enqueues value, action 1 dequeues
// the smallest held value. Equal values leave in arrival order.
// Output channel (out_valid/out_ready): one result beat per input beat with
// result_value, status (ok, overflow, underflow), count, is_empty and is_full.
// The result is registered and appears in the cycle after the input beat is taken.
// Throughput: one item per cycle while the receiver does not stall. Every slot
// compares against the new value in parallel and takes its left or right
// neighbor in the same edge, so the chain of cells never holds up the input.
// A result held in the output register blocks the input only while the
// receiver stalls: in_ready is high whenever the output register is empty or
// being drained in the same cycle.
// Reset empties the queue (count to zero) and drops any pending result; slot
// contents are not cleared, only slots below the count are ever read.
// count is the held entry count modulo 32.
module sorted_priority_queue_core #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic signed [spq_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spq_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                        status,
  output logic [spq_pkg::COUNT_W-1:0]       count,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                      held;
  logic [CW-1:0]                      held_next;
  logic                               accept;
  logic                               q_empty;
  logic                               q_full;
  spq_pkg::cell_ctrl_t                ctrl;
  logic [CAPACITY-1:0]                occ;
  logic [CAPACITY-1:0]                cell_shift;
  logic signed [spq_pkg::DATA_W-1:0]  cell_value [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0]  result_next;
  logic [1:0]                         status_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign q_empty  = (held == '0);
  assign q_full   = (held == CW'(CAPACITY));

  // control broadcast to the chain
  assign ctrl.enq_en = accept && (action == spq_pkg::ACT_ENQ) && !q_full;
  assign ctrl.deq_en = accept && (action == spq_pkg::ACT_DEQ) && !q_empty;
  assign ctrl.value  = value;

  // chain of cells, slot 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              l_shift;
    logic signed [spq_pkg::DATA_W-1:0] l_value;
    logic signed [spq_pkg::DATA_W-1:0] r_value;

    assign occ[i] = (CW'(i) < held);

    if (i == 0) begin : g_first
      assign l_shift = 1'b0;
      assign l_value = value;
    end else begin : g_mid
      assign l_shift = cell_shift[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_value = cell_value[i];
    end else begin : g_inner
      assign r_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[i]),
      .left_shift  (l_shift),
      .left_value  (l_value),
      .right_value (r_value),
      .shift       (cell_shift[i]),
      .slot_value  (cell_value[i])
    );
  end

  // next count and result fields
  always_comb begin
    held_next   = held;
    result_next = '0;
    status_next = spq_pkg::ST_OK;
    unique case (action)
      spq_pkg::ACT_ENQ: begin
        if (q_full) begin
          status_next = spq_pkg::ST_OVERFLOW;
        end else begin
          held_next = held + CW'(1);
        end
      end
      spq_pkg::ACT_DEQ: begin
        if (q_empty) begin
          status_next = spq_pkg::ST_UNDERFLOW;
          result_next = '1;
        end else begin
          result_next = cell_value[0];
          held_next   = held - CW'(1);
        end
      end
      default: begin
        held_next = held;
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result_value <= result_next;
      status       <= status_next;
      count        <= spq_pkg::COUNT_W'(held_next);
      is_empty     <= (held_next == '0);
      is_full      <= (held_next == CW'(CAPACITY));
    end
  end

endmodule

/* hdl/spq_checker.sv */
// port-level checks of the queue, bound to the top level
`include "sorted_priority_queue_core_assert.svh"

module spq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [spq_pkg::DATA_W-1:0] result_value,
  input logic [1:0]                        status,
  input logic [spq_pkg::COUNT_W-1:0]       count,
  input logic                              is_empty,
  input logic                              is_full
);

  // stalled result beat holds its value
  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(result_value);
  endproperty

  // underflow returns minus one on an empty queue
  property p_underflow;
    out_valid && status == spq_pkg::ST_UNDERFLOW |->
      result_value == -1 && is_empty && count == 0;
  endproperty

  // overflow only on a full queue and returns zero
  property p_overflow;
    out_valid && status == spq_pkg::ST_OVERFLOW |->
      is_full && !is_empty && result_value == 0;
  endproperty

  `SPQ_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")

  `SPQ_ASSERT(a_underflow, p_underflow, "bad underflow beat")

  `SPQ_ASSERT(a_overflow, p_overflow, "bad overflow beat")

  // reset drops any pending result
  `SPQ_ASSERT_RST(a_reset_idle, rst |=> !out_valid, "result pending after reset")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .status       (status),
  .count        (count),
  .is_empty     (is_empty),
  .is_full      (is_full)
);

/* tb/sorted_priority_queue_core_test.sv */
// self-checking testbench for the sorted minimum priority queue core
module sorted_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = spq_pkg::CAPACITY_DEF;

  // one queue operation as offered on the input channel
  typedef struct {
    logic                              act;
    logic signed [spq_pkg::DATA_W-1:0] val;
    bit                                hold_until_drained;
  } queue_op_t;

  // one result beat as the queue should return it
  typedef struct {
    logic                              act;
    logic signed [spq_pkg::DATA_W-1:0] result_value;
    logic [1:0]                        status;
    logic [spq_pkg::COUNT_W-1:0]       count;
    logic                              is_empty;
    logic                              is_full;
  } queue_outcome_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              action = spq_pkg::ACT_ENQ;
  logic signed [spq_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [spq_pkg::DATA_W-1:0] result_value;
  logic [1:0]                        status;
  logic [spq_pkg::COUNT_W-1:0]       count;
  logic                              is_empty;
  logic                              is_full;

  sorted_priority_queue_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status),
    .count        (count),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  always #6ns clk = ~clk;

  queue_op_t                         op_backlog[$];
  queue_outcome_t                    expected_outcomes[$];
  logic signed [spq_pkg::DATA_W-1:0] shadow_entries[$];

  int beats_sent = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int n_enq_ok = 0;
  int n_deq_ok = 0;
  int n_overflow = 0;
  int n_underflow = 0;
  int peak_depth = 0;

  // sorted insert / pop-min on the shadow store, returns the expected beat
  function automatic queue_outcome_t apply_queue_op(
    logic act, logic signed [spq_pkg::DATA_W-1:0] val);
    queue_outcome_t o;
    int pos;
    o.act = act;
    o.result_value = '0;
    o.status = spq_pkg::ST_OK;
    if (act == spq_pkg::ACT_ENQ) begin
      if (shadow_entries.size() >= CAP) begin
        o.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // new value goes behind every equal or smaller entry
        pos = shadow_entries.size();
        while (pos > 0 && shadow_entries[pos-1] > val) pos--;
        shadow_entries.insert(pos, val);
      end
    end else if (shadow_entries.size() == 0) begin
      o.status = spq_pkg::ST_UNDERFLOW;
      o.result_value = '1;
    end else begin
      o.result_value = shadow_entries.pop_front();
    end
    o.count = spq_pkg::COUNT_W'(shadow_entries.size());
    o.is_empty = (shadow_entries.size() == 0);
    o.is_full = (shadow_entries.size() == CAP);
    return o;
  endfunction

  function automatic void add_op(
    logic act, logic signed [spq_pkg::DATA_W-1:0] val, bit drain);
    queue_op_t op;
    op.act = act;
    op.val = val;
    op.hold_until_drained = drain;
    op_backlog.push_back(op);
  endfunction

  // mix of full-range, tightly clustered and corner values
  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // driver: bursts of beats separated by random gaps
  int        burst_left = 0;
  int        gap_left = 0;
  queue_op_t cur_op;
  bit        took;
  bit        launch;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        expected_outcomes.push_back(apply_queue_op(cur_op.act, cur_op.val));
        beats_sent <= beats_sent + 1;
        if (shadow_entries.size() > peak_depth) peak_depth = shadow_entries.size();
      end
      // hold the beat until the core takes it
      if (!(in_valid && !in_ready)) begin
        launch = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_backlog.size() > 0) begin
          if (!(op_backlog[0].hold_until_drained &&
                (beats_sent - beats_checked + int'(took)) != 0)) begin
            cur_op = op_backlog.pop_front();
            launch = 1'b1;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
              gap_left = $urandom_range(0, 7);
            end
          end
        end
        in_valid <= launch;
        if (launch) begin
          action <= cur_op.act;
          value <= cur_op.val;
        end
      end
    end
  end

  // monitor: checks each result beat and drives its own stall pattern
  int             ready_mode = 0;
  int             mode_left = 0;
  int             cyc = 0;
  queue_outcome_t exp;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      cyc++;
      if (out_valid && out_ready) begin
        if (beats_checked >= beats_sent) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          exp = expected_outcomes.pop_front();
          beats_checked <= beats_checked + 1;
          if (result_value !== exp.result_value) begin
            $error("result_value: expected %0d, got %0d", exp.result_value, result_value);
            mismatches++;
          end
          if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            mismatches++;
          end
          if (count !== exp.count) begin
            $error("count: expected %0d, got %0d", exp.count, count);
            mismatches++;
          end
          if (is_empty !== exp.is_empty) begin
            $error("is_empty: expected %0b, got %0b", exp.is_empty, is_empty);
            mismatches++;
          end
          if (is_full !== exp.is_full) begin
            $error("is_full: expected %0b, got %0b", exp.is_full, is_full);
            mismatches++;
          end
          case (exp.status)
            spq_pkg::ST_OVERFLOW:  n_overflow++;
            spq_pkg::ST_UNDERFLOW: n_underflow++;
            default: begin
              if (exp.act == spq_pkg::ACT_ENQ) n_enq_ok++;
              else n_deq_ok++;
            end
          endcase
        end
      end
      // stall pattern: always ready, coin flip, sparse, or a periodic pattern set by the cycle counter
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cyc % 4 != 0);
      endcase
    end
  end

  // stimulus, then wait for the queue to drain and report
  initial begin
    int enq_pct;
    // empty dequeue, extremes and duplicates
    add_op(spq_pkg::ACT_DEQ, 32'sh12345678, 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sh7fffffff, 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sh80000000, 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sh0, 1'b0);
    add_op(spq_pkg::ACT_ENQ, -32'sd1, 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sd1, 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sh0, 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sh80000000, 1'b0);
    add_op(spq_pkg::ACT_DEQ, 32'sh0, 1'b0);
    // fill to capacity, then one dropped enqueue
    for (int i = 0; i < CAP - 6; i++) add_op(spq_pkg::ACT_ENQ, pick_value(), 1'b0);
    add_op(spq_pkg::ACT_ENQ, 32'sh5a5a5a5a, 1'b0);
    add_op(spq_pkg::ACT_DEQ, 32'sh0, 1'b0);
    add_op(spq_pkg::ACT_DEQ, 32'sh0, 1'b0);

    // random phases biased toward filling, draining or churning
    for (int seg = 0; seg < 15; seg++) begin
      case ($urandom_range(0, 4))
        0: enq_pct = 85;
        1: enq_pct = 15;
        2: enq_pct = 95;
        3: enq_pct = 5;
        default: enq_pct = 50;
      endcase
      for (int i = 0; i < 40; i++) begin
        add_op($urandom_range(0, 99) < enq_pct ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ,
               pick_value(), i == 0 && seg % 5 == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so driver and monitor updates have settled
    while (op_backlog.size() > 0 || in_valid || beats_checked != beats_sent)
      @(negedge clk);
    repeat (5) @(posedge clk);
    if (beats_checked != beats_sent || expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      mismatches++;
    end

    $display("checked %0d beats: %0d enqueues, %0d dequeues, %0d overflows, %0d underflows",
             beats_checked, n_enq_ok, n_deq_ok, n_overflow, n_underflow);
    $display("deepest queue reached %0d of %0d entries", peak_depth, CAP);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
